### sv/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types, register indexes and the kelvin-to-Celsius conversion for the
// thermal ROI statistics unit.
// ----------------------------------------------------------------------------
package trs_pkg;

  localparam int PixW   = 16;
  localparam int CoordW = 8;
  localparam int DimW   = 9;
  localparam int SumW   = 32;
  localparam int CountW = 17;
  localparam int CentiW = 18;
  localparam int CfgIdxW = 3;

  localparam logic [CountW-1:0] CountCap    = '1;
  localparam logic [CentiW-1:0] CentiOffset = 18'd27315;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROI_LEFT   = 3'd0,
    CFG_ROI_TOP    = 3'd1,
    CFG_ROI_COLS   = 3'd2,
    CFG_ROI_ROWS   = 3'd3,
    CFG_FRAME_COLS = 3'd4,
    CFG_FRAME_ROWS = 3'd5
  } cfg_idx_e;

  // Frame summary handed from the front to the back
  typedef struct packed {
    logic              valid;
    logic [PixW-1:0]   min_val;
    logic [PixW-1:0]   max_val;
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
  } trs_snap_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIV,
    BACK_DONE
  } back_state_e;

  // floor((raw*25 + 8) / 16) - 27315, as an 18-bit signed value
  function automatic logic signed [CentiW-1:0] to_centi(input logic [PixW-1:0] raw);
    logic [PixW+4:0] prod;
    logic [PixW:0]   scaled;
    prod   = {1'b0, raw, 4'b0000} + {2'b00, raw, 3'b000} + {5'b00000, raw} + 21'd8;
    scaled = prod[PixW+4:4];
    return $signed({1'b0, scaled}) - $signed(CentiOffset);
  endfunction

endpackage

### sv/thermal_roi_statistics_unit.sv
// ----------------------------------------------------------------------------
// thermal_roi_statistics_unit
// Min, max and mean of thermal pixels inside a programmable rectangle.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock. The front keeps running statistics and on
// each end-of-frame pixel pushes a frame summary into a two-entry queue; the
// pixel stream stalls only while that queue is full. The back pops a summary
// from the queue, runs the sum/count divider one quotient bit at a time and
// then loads the output register once it is free; an invalid summary skips
// the divider. A result held by the receiver holds the back, and the queue
// then fills. Registers are written through the cfg port only while the unit
// holds no pending frame: the user must keep to this, as the unit does not
// enforce it; cfg_ready_o is always high.
module thermal_roi_statistics_unit #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [8:0]   cfg_data_i,
  // pixel stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // pixel_value[15:0], pixel_col[23:16], pixel_row[31:24]
  input  logic         s_axis_tlast,  // frame_end
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // max_raw, min_raw, mean_raw (16 each), max_centi_c,
                                      // min_centi_c, mean_centi_c (18 each), 2 pad bits
  output logic         m_axis_tuser   // stats_valid
);
  import trs_pkg::*;

  logic      snap_push, snap_pop, snap_full, snap_empty;
  trs_snap_t snap_in, snap_out;

  trs_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_value_i (s_axis_tdata[15:0]),
    .pix_col_i   (s_axis_tdata[23:16]),
    .pix_row_i   (s_axis_tdata[31:24]),
    .frame_end_i (s_axis_tlast),
    .snap_push_o (snap_push),
    .snap_o      (snap_in),
    .snap_full_i (snap_full)
  );

  trs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .data_i  (snap_in),
    .full_o  (snap_full),
    .pop_i   (snap_pop),
    .empty_o (snap_empty),
    .data_o  (snap_out)
  );

  trs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .snap_empty_i      (snap_empty),
    .snap_i            (snap_out),
    .snap_pop_o        (snap_pop),
    .res_valid_o       (m_axis_tvalid),
    .res_ready_i       (m_axis_tready),
    .res_stats_valid_o (m_axis_tuser),
    .res_data_o        (m_axis_tdata)
  );

endmodule

### sv/trs_front.sv
// ----------------------------------------------------------------------------
// trs_front
// Holds the ROI registers, tests each pixel against the rectangle and keeps
// running min, max, sum and count; emits one frame summary per frame end.
// ----------------------------------------------------------------------------
module trs_front #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [trs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [trs_pkg::DimW-1:0]    cfg_data_i,
  input  logic                        pix_valid_i,
  output logic                        pix_ready_o,
  input  logic [trs_pkg::PixW-1:0]    pix_value_i,
  input  logic [trs_pkg::CoordW-1:0]  pix_col_i,
  input  logic [trs_pkg::CoordW-1:0]  pix_row_i,
  input  logic                        frame_end_i,
  output logic                        snap_push_o,
  output trs_pkg::trs_snap_t          snap_o,
  input  logic                        snap_full_i
);
  import trs_pkg::*;

  localparam logic [12:0] MaxColsC = 13'(MAX_COLS);
  localparam logic [12:0] MaxRowsC = 13'(MAX_ROWS);

  logic [CoordW-1:0] roi_left_q, roi_top_q;
  logic [DimW-1:0]   roi_cols_q, roi_rows_q, frame_cols_q, frame_rows_q;

  logic [PixW-1:0]   min_q, min_d, max_q, max_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CountW-1:0] count_q, count_d;

  logic              accept;
  logic              in_roi;
  logic [DimW:0]     col_end, row_end;
  logic [12:0]       img_w, img_h;
  logic [SumW:0]     sum_wide;
  logic [PixW-1:0]   min_u, max_u;
  logic [SumW-1:0]   sum_u;
  logic [CountW-1:0] count_u;

  assign cfg_ready_o = 1'b1;
  assign pix_ready_o = !snap_full_i;
  assign accept      = pix_valid_i && pix_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_left_q   <= '0;
      roi_top_q    <= '0;
      roi_cols_q   <= 9'd256;
      roi_rows_q   <= 9'd192;
      frame_cols_q <= 9'd256;
      frame_rows_q <= 9'd192;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROI_LEFT:   roi_left_q   <= cfg_data_i[CoordW-1:0];
        CFG_ROI_TOP:    roi_top_q    <= cfg_data_i[CoordW-1:0];
        CFG_ROI_COLS:   roi_cols_q   <= cfg_data_i;
        CFG_ROI_ROWS:   roi_rows_q   <= cfg_data_i;
        CFG_FRAME_COLS: frame_cols_q <= cfg_data_i;
        CFG_FRAME_ROWS: frame_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    col_end = {2'b00, roi_left_q} + {1'b0, roi_cols_q};
    row_end = {2'b00, roi_top_q} + {1'b0, roi_rows_q};
    in_roi  = (pix_col_i >= roi_left_q) && ({2'b00, pix_col_i} < col_end) &&
              (pix_row_i >= roi_top_q) && ({2'b00, pix_row_i} < row_end);

    img_w = ({4'b0, frame_cols_q} < MaxColsC) ? {4'b0, frame_cols_q} : MaxColsC;
    img_h = ({4'b0, frame_rows_q} < MaxRowsC) ? {4'b0, frame_rows_q} : MaxRowsC;

    // saturating accumulate
    sum_wide = {1'b0, sum_q} + {{(SumW-PixW+1){1'b0}}, pix_value_i};
    min_u    = (pix_value_i < min_q) ? pix_value_i : min_q;
    max_u    = (pix_value_i > max_q) ? pix_value_i : max_q;
    sum_u    = sum_wide[SumW] ? '1 : sum_wide[SumW-1:0];
    count_u  = (count_q == CountCap) ? count_q : count_q + CountW'(1);
    if (!in_roi) begin
      min_u   = min_q;
      max_u   = max_q;
      sum_u   = sum_q;
      count_u = count_q;
    end

    snap_o.valid   = (roi_cols_q != '0) && (roi_rows_q != '0) &&
                     ({3'b000, col_end} <= img_w) && ({3'b000, row_end} <= img_h) &&
                     (count_u != '0);
    snap_o.min_val = min_u;
    snap_o.max_val = max_u;
    snap_o.sum     = sum_u;
    snap_o.count   = count_u;
    snap_push_o    = accept && frame_end_i;

    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    count_d = count_q;
    if (accept) begin
      if (frame_end_i) begin
        // clear for the next frame
        min_d   = '1;
        max_d   = '0;
        sum_d   = '0;
        count_d = '0;
      end else begin
        min_d   = min_u;
        max_d   = max_u;
        sum_d   = sum_u;
        count_d = count_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '1;
      max_q   <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      min_q   <= min_d;
      max_q   <= max_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

endmodule

### sv/trs_fifo.sv
// ----------------------------------------------------------------------------
// trs_fifo
// Two-entry queue of frame summaries between the front and the back.
// ----------------------------------------------------------------------------
module trs_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  trs_pkg::trs_snap_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output trs_pkg::trs_snap_t data_o
);
  import trs_pkg::*;

  trs_snap_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = fill_q[1];
  assign empty_o = (fill_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

### sv/trs_back.sv
// ----------------------------------------------------------------------------
// trs_back
// Pops a frame summary; for a valid one divides sum by count one quotient bit
// a cycle and converts min, max and mean to centi-Celsius; holds the result.
// ----------------------------------------------------------------------------
module trs_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      snap_empty_i,
  input  trs_pkg::trs_snap_t        snap_i,
  output logic                      snap_pop_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic                      res_stats_valid_o,
  output logic [103:0]              res_data_o
);
  import trs_pkg::*;

  back_state_e state_q, state_d;

  logic              valid_q;
  logic [PixW-1:0]   min_q, max_q;
  logic [SumW-1:0]   quo_q;
  logic [CountW-1:0] rem_q, count_q;
  logic [4:0]        step_q;

  logic [CountW:0]   trial;
  logic [CountW:0]   diff;
  logic              fits;
  logic [PixW-1:0]   mean;
  logic              load_out;

  logic              out_valid_q;
  logic              out_stats_q;
  logic [103:0]      out_data_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BACK_IDLE: begin
        if (!snap_empty_i) begin
          state_d = snap_i.valid ? BACK_DIV : BACK_DONE;
        end
      end
      BACK_DIV: begin
        if (step_q == '1) begin
          state_d = BACK_DONE;
        end
      end
      BACK_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          state_d = BACK_IDLE;
        end
      end
      default: state_d = BACK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    snap_pop_o = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      BACK_IDLE: snap_pop_o = !snap_empty_i;
      BACK_DIV:  ;
      BACK_DONE: load_out = !out_valid_q || res_ready_i;
      default:   ;
    endcase
  end

  always_comb begin
    trial = {rem_q, quo_q[SumW-1]};
    diff  = trial - {1'b0, count_q};
    fits  = (trial >= {1'b0, count_q});
    mean  = (quo_q[SumW-1:PixW] != '0) ? '1 : quo_q[PixW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_q == BACK_DIV) ? step_q + 5'd1 : '0;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (snap_pop_o) begin
      valid_q <= snap_i.valid;
      min_q   <= snap_i.min_val;
      max_q   <= snap_i.max_val;
      quo_q   <= snap_i.sum;
      count_q <= snap_i.count;
      rem_q   <= '0;
    end else if (state_q == BACK_DIV) begin
      rem_q <= fits ? diff[CountW-1:0] : trial[CountW-1:0];
      quo_q <= {quo_q[SumW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_stats_q <= valid_q;
      if (valid_q) begin
        out_data_q <= {2'b00, to_centi(mean), to_centi(min_q), to_centi(max_q),
                       mean, min_q, max_q};
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign res_valid_o       = out_valid_q;
  assign res_stats_valid_o = out_stats_q;
  assign res_data_o        = out_data_q;

endmodule

### bench/tb_thermal_roi_statistics_unit.sv
// ----------------------------------------------------------------------------
// tb_thermal_roi_statistics_unit
// Self-checking bench for the thermal ROI statistics unit. A short table of
// hand-picked pixels runs first, then one back-to-back frame of full-scale
// pixels, then phases of random frames under a series of rectangle and
// image settings. Each frame summary, predicted from the accepted pixels or
// set by hand in the table, is compared field by field with the result stream.
// ----------------------------------------------------------------------------
module tb_thermal_roi_statistics_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import trs_pkg::*;

  localparam int ImgColsMax        = 256;
  localparam int ImgRowsMax        = 256;
  localparam int KelvinOffsetCenti = 27315;
  localparam int BackLatency       = 40;
  localparam int HoldOffCycles     = 400;
  localparam int ReportLimit       = 10;
  localparam int BurstPixels       = 32;
  localparam int ItemsPerPhase     = 90;
  localparam int FixedCount        = 11;
  localparam int PhaseCount        = 15;
  localparam int PressurePhase     = 2;
  localparam int DirCount          = 14;
  localparam int LimitNs           = 10_000_000;

  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  typedef struct packed {
    logic                     valid;
    logic [PixW-1:0]          max_raw;
    logic [PixW-1:0]          min_raw;
    logic [PixW-1:0]          mean_raw;
    logic signed [CentiW-1:0] max_c;
    logic signed [CentiW-1:0] min_c;
    logic signed [CentiW-1:0] mean_c;
  } roi_stats_t;

  localparam roi_stats_t NoStats = '{1'b0, 16'd0, 16'd0, 16'd0, 18'sd0, 18'sd0, 18'sd0};

  typedef struct packed {
    logic [PixW-1:0]   val;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              last;
    logic              fixed_exp;
    roi_stats_t        want;
  } pixel_case_t;

  typedef struct packed {
    int left;
    int top;
    int cols;
    int rows;
    int fcols;
    int frows;
  } roi_setup_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [8:0]   cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;   // pixel_value[15:0], pixel_col[23:16], pixel_row[31:24]
  logic         s_axis_tlast;   // frame_end
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;   // max_raw, min_raw, mean_raw, max_centi_c, min_centi_c,
                                // mean_centi_c, pad
  logic         m_axis_tuser;   // stats_valid

  // predicted register file and running statistics
  logic [CoordW-1:0] roi_left_q, roi_top_q;
  logic [DimW-1:0]   roi_cols_q, roi_rows_q, img_cols_q, img_rows_q;
  logic [PixW-1:0]   acc_min, acc_max;
  logic [SumW-1:0]   acc_sum;
  logic [CountW-1:0] acc_count;

  roi_stats_t summary_q[$];
  int         mismatch_cnt = 0;
  bit         idle_on = 1'b1;
  bit         hold_off_pending = 1'b0;
  bit         short_frames = 1'b0;

  // Reset ROI is 0,0,256x192 on a 256x192 image
  pixel_case_t pixel_cases [DirCount] = '{
    '{16'd0,     8'd0,   8'd0,   1'b1, 1'b1,
      '{1'b1, 16'd0, 16'd0, 16'd0, -18'sd27315, -18'sd27315, -18'sd27315}},
    '{16'd65535, 8'd255, 8'd191, 1'b1, 1'b1,
      '{1'b1, 16'd65535, 16'd65535, 16'd65535, 18'sd75083, 18'sd75083, 18'sd75083}},
    '{16'd1234,  8'd0,   8'd192, 1'b1, 1'b1, NoStats},
    '{16'd1,     8'd0,   8'd0,   1'b1, 1'b1,
      '{1'b1, 16'd1, 16'd1, 16'd1, -18'sd27313, -18'sd27313, -18'sd27313}},
    '{16'd4660,  8'd255, 8'd255, 1'b0, 1'b0, NoStats},
    '{16'd100,   8'd128, 8'd64,  1'b0, 1'b0, NoStats},
    '{16'd65535, 8'd0,   8'd0,   1'b0, 1'b0, NoStats},
    '{16'd0,     8'd255, 8'd191, 1'b1, 1'b0, NoStats},
    '{16'd32768, 8'd17,  8'd33,  1'b0, 1'b0, NoStats},
    '{16'd43690, 8'd34,  8'd68,  1'b0, 1'b0, NoStats},
    '{16'd21845, 8'd170, 8'd85,  1'b0, 1'b0, NoStats},
    '{16'd65535, 8'd0,   8'd192, 1'b1, 1'b0, NoStats},
    '{16'd65535, 8'd255, 8'd0,   1'b0, 1'b0, NoStats},
    '{16'd7,     8'd0,   8'd191, 1'b1, 1'b0, NoStats}
  };

  roi_setup_t fixed_setups [FixedCount] = '{
    '{10,  20,  100, 8,   256, 192},
    '{255, 255, 1,   1,   256, 256},
    '{0,   0,   256, 256, 256, 256},
    '{0,   0,   0,   10,  256, 192},
    '{5,   5,   10,  0,   256, 192},
    '{250, 0,   7,   4,   256, 192},
    '{0,   189, 4,   4,   256, 192},
    '{0,   0,   1,   1,   1,   1},
    '{200, 100, 56,  128, 511, 300},
    '{200, 240, 57,  16,  511, 511},
    '{16,  8,   128, 112, 160, 120}
  };

  thermal_roi_statistics_unit #(
    .MAX_COLS(ImgColsMax),
    .MAX_ROWS(ImgRowsMax)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(LimitNs);
    $display("Mismatches found");
    $finish;
  end

  // 1/64 K to hundredths of a degree Celsius, rounded to nearest
  function automatic logic signed [CentiW-1:0] kelvin64_to_centi_c(input logic [PixW-1:0] raw);
    int unsigned scaled;
    scaled = (32'(raw) * 32'd25 + 32'd8) >> 4;
    return CentiW'(int'(scaled) - KelvinOffsetCenti);
  endfunction

  // Fold one pixel into the running statistics; on frame end, produce the summary
  function automatic bit track_pixel(input logic [PixW-1:0] val,
                                     input logic [CoordW-1:0] col,
                                     input logic [CoordW-1:0] row,
                                     input logic last,
                                     output roi_stats_t res);
    int              img_w, img_h;
    logic [SumW:0]   wide_sum;
    logic [SumW-1:0] mean;
    res = NoStats;
    if (int'(col) >= int'(roi_left_q) && int'(col) < int'(roi_left_q) + int'(roi_cols_q) &&
        int'(row) >= int'(roi_top_q) && int'(row) < int'(roi_top_q) + int'(roi_rows_q)) begin
      if (val < acc_min) acc_min = val;
      if (val > acc_max) acc_max = val;
      wide_sum = {1'b0, acc_sum} + (SumW+1)'(val);
      acc_sum  = wide_sum[SumW] ? '1 : wide_sum[SumW-1:0];
      if (acc_count != '1) acc_count++;
    end
    if (!last) return 1'b0;

    img_w = int'(img_cols_q) < ImgColsMax ? int'(img_cols_q) : ImgColsMax;
    img_h = int'(img_rows_q) < ImgRowsMax ? int'(img_rows_q) : ImgRowsMax;
    if (roi_cols_q != 0 && roi_rows_q != 0 && acc_count != 0 &&
        int'(roi_left_q) + int'(roi_cols_q) <= img_w &&
        int'(roi_top_q) + int'(roi_rows_q) <= img_h) begin
      mean         = acc_sum / SumW'(acc_count);
      res.valid    = 1'b1;
      res.max_raw  = acc_max;
      res.min_raw  = acc_min;
      res.mean_raw = (mean >> PixW) != 0 ? '1 : mean[PixW-1:0];
      res.max_c    = kelvin64_to_centi_c(res.max_raw);
      res.min_c    = kelvin64_to_centi_c(res.min_raw);
      res.mean_c   = kelvin64_to_centi_c(res.mean_raw);
    end
    acc_min   = '1;
    acc_max   = '0;
    acc_sum   = '0;
    acc_count = '0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= ReportLimit)
        $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  // Edge-biased coordinate around a span, with some fully random picks
  function automatic logic [CoordW-1:0] pick_coord(input int lo, input int span);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5 && span > 0) return CoordW'(lo + $urandom_range(0, span - 1));
    if (sel == 6) return CoordW'(lo - 1);
    if (sel == 7) return CoordW'(lo + span);
    if (sel == 8) return CoordW'(lo + span - 1);
    return CoordW'($urandom);
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROI_LEFT:   roi_left_q = data[CoordW-1:0];
      CFG_ROI_TOP:    roi_top_q  = data[CoordW-1:0];
      CFG_ROI_COLS:   roi_cols_q = data;
      CFG_ROI_ROWS:   roi_rows_q = data;
      CFG_FRAME_COLS: img_cols_q = data;
      CFG_FRAME_ROWS: img_rows_q = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input roi_setup_t s);
    write_reg(CFG_ROI_LEFT,   DimW'(s.left));
    write_reg(CFG_ROI_TOP,    DimW'(s.top));
    write_reg(CFG_ROI_COLS,   DimW'(s.cols));
    write_reg(CFG_ROI_ROWS,   DimW'(s.rows));
    write_reg(CFG_FRAME_COLS, DimW'(s.fcols));
    write_reg(CFG_FRAME_ROWS, DimW'(s.frows));
    // unmapped indexes must leave the registers alone
    write_reg(CfgSpareLo, DimW'($urandom));
    write_reg(CfgSpareHi, DimW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PixW-1:0] val, input logic [CoordW-1:0] col,
                            input logic [CoordW-1:0] row, input logic last,
                            input logic fixed_exp, input roi_stats_t want);
    roi_stats_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, col, val};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (track_pixel(val, col, row, last, pred))
      summary_q.push_back(fixed_exp ? want : pred);
  endtask

  task automatic run_frame(input bit noise, inout int items);
    int                n;
    logic [PixW-1:0]   val;
    logic [CoordW-1:0] col, row;
    n = short_frames ? $urandom_range(1, 2) : $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = '1;
        default: val = PixW'($urandom);
      endcase
      col = noise ? CoordW'($urandom) : pick_coord(int'(roi_left_q), int'(roi_cols_q));
      row = noise ? CoordW'($urandom) : pick_coord(int'(roi_top_q), int'(roi_rows_q));
      send_pixel(val, col, row, k == n - 1, 1'b0, NoStats);
    end
    items += n;
  endtask

  // Drop valid, wait out every pending summary and the back stage
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk_i);
    repeat (BackLatency) @(posedge clk_i);
  endtask

  // Result sink with random stalls and one long hold-off
  initial begin : result_sink
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < HoldOffCycles; c++) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    roi_stats_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.valid    = m_axis_tuser;
      got.max_raw  = m_axis_tdata[15:0];
      got.min_raw  = m_axis_tdata[31:16];
      got.mean_raw = m_axis_tdata[47:32];
      got.max_c    = $signed(m_axis_tdata[65:48]);
      got.min_c    = $signed(m_axis_tdata[83:66]);
      got.mean_c   = $signed(m_axis_tdata[101:84]);
      if (summary_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ReportLimit)
          $display("[%0t] result with none expected: stats_valid %0d max_raw %0d",
                   $realtime, got.valid, got.max_raw);
      end else begin
        want = summary_q.pop_front();
        check_field("stats_valid",  int'(want.valid),    int'(got.valid));
        check_field("max_raw",      int'(want.max_raw),  int'(got.max_raw));
        check_field("min_raw",      int'(want.min_raw),  int'(got.min_raw));
        check_field("mean_raw",     int'(want.mean_raw), int'(got.mean_raw));
        check_field("max_centi_c",  int'(want.max_c),    int'(got.max_c));
        check_field("min_centi_c",  int'(want.min_c),    int'(got.min_c));
        check_field("mean_centi_c", int'(want.mean_c),   int'(got.mean_c));
      end
    end
  end

  initial begin : stimulus
    roi_setup_t setup;
    int         phase_items;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    roi_left_q = '0;
    roi_top_q  = '0;
    roi_cols_q = DimW'(256);
    roi_rows_q = DimW'(192);
    img_cols_q = DimW'(256);
    img_rows_q = DimW'(192);
    acc_min    = '1;
    acc_max    = '0;
    acc_sum    = '0;
    acc_count  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pixel_cases[i])
      send_pixel(pixel_cases[i].val, pixel_cases[i].col, pixel_cases[i].row,
                 pixel_cases[i].last, pixel_cases[i].fixed_exp, pixel_cases[i].want);

    // Full-scale pixels on one spot, back to back in one frame
    idle_on = 1'b0;
    for (int k = 0; k < BurstPixels; k++)
      send_pixel('1, '0, '0, k == BurstPixels - 1, 1'b0, NoStats);
    idle_on = 1'b1;
    settle();

    for (int p = 0; p < PhaseCount; p++) begin
      if (p < FixedCount) begin
        setup = fixed_setups[p];
      end else begin
        setup.fcols = $urandom_range(1, ImgColsMax);
        setup.frows = $urandom_range(1, ImgRowsMax);
        setup.left  = $urandom_range(0, setup.fcols - 1);
        setup.top   = $urandom_range(0, setup.frows - 1);
        setup.cols  = $urandom_range(1, setup.fcols - setup.left);
        setup.rows  = $urandom_range(1, setup.frows - setup.top);
      end
      idle_on = (p != PhaseCount - 1);
      apply_settings(setup);
      if (p == PressurePhase) begin
        hold_off_pending = 1'b1;
        short_frames     = 1'b1;
      end
      phase_items = 0;
      while (phase_items < ItemsPerPhase)
        run_frame($urandom_range(0, 7) == 0, phase_items);
      short_frames = 1'b0;
      settle();
    end

    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### thermal_roi_statistics_unit.f
sv/trs_pkg.sv
sv/trs_front.sv
sv/trs_fifo.sv
sv/trs_back.sv
sv/thermal_roi_statistics_unit.sv
bench/tb_thermal_roi_statistics_unit.sv
